// ----- rtl/hkm_pkg.sv -----
// Shared types and constants for the heartbeat keepalive monitor.
package hkm_pkg;

  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [7:0] BYTE_PING = 8'd73;
  localparam logic [7:0] BYTE_PONG = 8'd79;

  localparam logic [CNT_W-1:0] PING_PERIOD_RST  = 16'd300;
  localparam logic [CNT_W-1:0] PONG_TIMEOUT_RST = 16'd15;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_RX      = 2'd1;
  localparam logic [1:0] CMD_TX_FAIL = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_IDLE  = 2'd2;
  localparam logic [1:0] PH_LOST  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PING_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PONG_TIMEOUT = 1'd1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       link_lost;
    logic       awaiting_pong;
  } out_word_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ----- rtl/hkm_engine.sv -----
// Link state, counters and per-word step logic of the keepalive monitor.
module hkm_engine (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  hkm_pkg::in_word_t        word,
  input  logic [hkm_pkg::CNT_W-1:0] ping_period,
  input  logic [hkm_pkg::CNT_W-1:0] pong_timeout,
  output hkm_pkg::out_word_t       result
);

  logic [1:0]                phase_r,      phase_nxt;
  logic [hkm_pkg::CNT_W-1:0] since_ping_r, since_ping_nxt;
  logic [hkm_pkg::CNT_W-1:0] silence_r,    silence_nxt;
  logic                      tx;
  logic [7:0]                txb;
  logic [hkm_pkg::CNT_W-1:0] since_inc, silence_inc;

  assign since_inc   = hkm_pkg::sat_inc(since_ping_r);
  assign silence_inc = hkm_pkg::sat_inc(silence_r);

  always_comb begin
    phase_nxt      = phase_r;
    since_ping_nxt = since_ping_r;
    silence_nxt    = silence_r;
    tx             = 1'b0;
    txb            = 8'd0;
    if (word.command != hkm_pkg::CMD_NONE) begin
      unique case (phase_r)
        hkm_pkg::PH_START: begin
          // first word only launches the ping
          tx             = 1'b1;
          txb            = hkm_pkg::BYTE_PING;
          phase_nxt      = hkm_pkg::PH_WAIT;
          since_ping_nxt = '0;
          silence_nxt    = '0;
        end
        hkm_pkg::PH_WAIT: begin
          if (word.command == hkm_pkg::CMD_TICK) begin
            since_ping_nxt = since_inc;
            silence_nxt    = silence_inc;
            if (silence_inc >= pong_timeout) phase_nxt = hkm_pkg::PH_LOST;
          end else if (word.command == hkm_pkg::CMD_TX_FAIL) begin
            phase_nxt = hkm_pkg::PH_LOST;
          end else if (word.rx_byte == hkm_pkg::BYTE_PING) begin
            tx          = 1'b1;
            txb         = hkm_pkg::BYTE_PONG;
            silence_nxt = '0;
          end else if (word.rx_byte == hkm_pkg::BYTE_PONG) begin
            silence_nxt = '0;
            if (since_ping_r >= ping_period) begin
              // late pong: next ping goes out right away
              tx             = 1'b1;
              txb            = hkm_pkg::BYTE_PING;
              since_ping_nxt = '0;
            end else begin
              phase_nxt = hkm_pkg::PH_IDLE;
            end
          end else begin
            phase_nxt = hkm_pkg::PH_LOST;
          end
        end
        hkm_pkg::PH_IDLE: begin
          if (word.command == hkm_pkg::CMD_TICK) begin
            since_ping_nxt = since_inc;
            if (since_inc >= ping_period) begin
              tx             = 1'b1;
              txb            = hkm_pkg::BYTE_PING;
              phase_nxt      = hkm_pkg::PH_WAIT;
              since_ping_nxt = '0;
              silence_nxt    = '0;
            end
          end else if (word.command == hkm_pkg::CMD_TX_FAIL) begin
            phase_nxt = hkm_pkg::PH_LOST;
          end else if (word.rx_byte == hkm_pkg::BYTE_PING) begin
            tx  = 1'b1;
            txb = hkm_pkg::BYTE_PONG;
          end
        end
        hkm_pkg::PH_LOST: begin
        end
      endcase
    end
  end

  assign result.tx_valid      = tx;
  assign result.tx_byte       = txb;
  assign result.link_lost     = (phase_nxt == hkm_pkg::PH_LOST);
  assign result.awaiting_pong = (phase_nxt == hkm_pkg::PH_WAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= hkm_pkg::PH_START;
      since_ping_r <= '0;
      silence_r    <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      since_ping_r <= since_ping_nxt;
      silence_r    <= silence_nxt;
    end
  end

endmodule

// ----- rtl/heartbeat_keepalive_monitor.sv -----
// Top level of the heartbeat keepalive monitor: input and result registers, config.
// Every accepted word, whatever its command, yields exactly one result word via the
// input and result registers; one word per cycle is sustained while out_ready is
// high. An input register feeds the step logic, which updates the link state and
// loads the result register in the same cycle, so a word can be accepted while a
// finished result still waits on out_ready. Config writes take effect at once.
module heartbeat_keepalive_monitor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  hkm_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output hkm_pkg::out_word_t            out_data,
  input  logic                          cfg_we,
  input  logic [hkm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hkm_pkg::CNT_W-1:0]     cfg_wdata
);

  logic                      in_v_r;
  hkm_pkg::in_word_t         in_word_r;
  logic                      out_v_r;
  hkm_pkg::out_word_t        out_word_r;
  hkm_pkg::out_word_t        step_result;
  logic [hkm_pkg::CNT_W-1:0] ping_period_r;
  logic [hkm_pkg::CNT_W-1:0] pong_timeout_r;
  logic                      advance;

  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) in_v_r <= in_valid;
      if (advance) out_v_r <= 1'b1;
      else if (out_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_word_r <= in_data;
    if (advance) out_word_r <= step_result;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_period_r  <= hkm_pkg::PING_PERIOD_RST;
      pong_timeout_r <= hkm_pkg::PONG_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hkm_pkg::CFG_PING_PERIOD:  ping_period_r  <= cfg_wdata;
        hkm_pkg::CFG_PONG_TIMEOUT: pong_timeout_r <= cfg_wdata;
      endcase
    end
  end

  hkm_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (advance),
    .word         (in_word_r),
    .ping_period  (ping_period_r),
    .pong_timeout (pong_timeout_r),
    .result       (step_result)
  );

  assign out_valid = out_v_r;
  assign out_data  = out_word_r;

endmodule

// ----- sim/tb_top.sv -----
// Testbench for the heartbeat keepalive monitor: queued driver, checking monitor, predictor.
module tb_top;
  import hkm_pkg::*;

  typedef struct {
    logic [1:0]       phase;
    logic [CNT_W-1:0] since_ping;
    logic [CNT_W-1:0] silence;
    logic [CNT_W-1:0] period;
    logic [CNT_W-1:0] timeout;
  } link_state_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  in_word_t    queued_events[$];
  out_word_t   expected_results[$];
  link_state_t model_link;
  link_state_t plan_link;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  int          sink_hold = 0;
  int          err_count = 0;

  heartbeat_keepalive_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] bump16(input logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic link_state_t link_after_reset();
    link_state_t s;
    s.phase      = PH_START;
    s.since_ping = '0;
    s.silence    = '0;
    s.period     = PING_PERIOD_RST;
    s.timeout    = PONG_TIMEOUT_RST;
    return s;
  endfunction

  // One event through the keepalive state machine; returns the result word.
  function automatic out_word_t keepalive_step(inout link_state_t st, input in_word_t w);
    out_word_t r;
    r = '0;
    if (w.command != CMD_NONE) begin
      case (st.phase)
        PH_START: begin
          // first event only launches the ping; its content is dropped
          r.tx_valid    = 1'b1;
          r.tx_byte     = BYTE_PING;
          st.phase      = PH_WAIT;
          st.since_ping = '0;
          st.silence    = '0;
        end
        PH_WAIT: begin
          if (w.command == CMD_TICK) begin
            st.since_ping = bump16(st.since_ping);
            st.silence    = bump16(st.silence);
            if (st.silence >= st.timeout) st.phase = PH_LOST;
          end else if (w.command == CMD_TX_FAIL) begin
            st.phase = PH_LOST;
          end else if (w.rx_byte == BYTE_PING) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = BYTE_PONG;
            st.silence = '0;
          end else if (w.rx_byte == BYTE_PONG) begin
            st.silence = '0;
            if (st.since_ping >= st.period) begin
              // late pong: next ping goes out right away
              r.tx_valid    = 1'b1;
              r.tx_byte     = BYTE_PING;
              st.since_ping = '0;
            end else begin
              st.phase = PH_IDLE;
            end
          end else begin
            st.phase = PH_LOST;
          end
        end
        PH_IDLE: begin
          if (w.command == CMD_TICK) begin
            st.since_ping = bump16(st.since_ping);
            if (st.since_ping >= st.period) begin
              r.tx_valid    = 1'b1;
              r.tx_byte     = BYTE_PING;
              st.phase      = PH_WAIT;
              st.since_ping = '0;
              st.silence    = '0;
            end
          end else if (w.command == CMD_TX_FAIL) begin
            st.phase = PH_LOST;
          end else if (w.rx_byte == BYTE_PING) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = BYTE_PONG;
          end
        end
        default: ;
      endcase
    end
    r.link_lost     = (st.phase == PH_LOST);
    r.awaiting_pong = (st.phase == PH_WAIT);
    return r;
  endfunction

  // Random event that keeps the link alive, given the planned state.
  function automatic in_word_t healthy_event(input link_state_t st);
    in_word_t w;
    int       r;
    w.rx_byte = 8'($urandom_range(255));
    w.command = CMD_TICK;
    r = $urandom_range(99);
    case (st.phase)
      PH_START: w.command = 2'($urandom_range(2));
      PH_WAIT: begin
        if (r < 8) begin
          w.command = CMD_NONE;
        end else if (r < 20 || (r >= 35 && bump16(st.silence) >= st.timeout)) begin
          w.command = CMD_RX;
          w.rx_byte = BYTE_PING;
        end else if (r < 35) begin
          w.command = CMD_RX;
          w.rx_byte = BYTE_PONG;
        end
      end
      PH_IDLE: begin
        if (r < 8) begin
          w.command = CMD_NONE;
        end else if (r < 16) begin
          w.command = CMD_RX;
          w.rx_byte = BYTE_PING;
        end else if (r < 28) begin
          w.command = CMD_RX;
        end
      end
      default: w.command = 2'($urandom_range(3));
    endcase
    return w;
  endfunction

  task automatic queue_event(input logic [1:0] cmd, input logic [7:0] rx);
    in_word_t w;
    w.command = cmd;
    w.rx_byte = rx;
    void'(keepalive_step(plan_link, w));
    queued_events.push_back(w);
  endtask

  task automatic queue_healthy(input int n);
    in_word_t w;
    repeat (n) begin
      w = healthy_event(plan_link);
      queue_event(w.command, w.rx_byte);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PING_PERIOD) begin
      model_link.period = val;
      plan_link.period  = val;
    end else begin
      model_link.timeout = val;
      plan_link.timeout  = val;
    end
  endtask

  task automatic drain();
    while (queued_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: prediction happens on the accepting edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(keepalive_step(model_link, in_data));
      if (!in_valid || in_ready) begin
        if (queued_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_data  <= queued_events.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each result word against the oldest prediction.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", out_data);
        err_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_data.tx_valid !== e.tx_valid) begin
          $error("tx_valid: expected %0d, actual %0d", e.tx_valid, out_data.tx_valid);
          err_count++;
        end
        if (out_data.tx_byte !== e.tx_byte) begin
          $error("tx_byte: expected %0d, actual %0d", e.tx_byte, out_data.tx_byte);
          err_count++;
        end
        if (out_data.link_lost !== e.link_lost) begin
          $error("link_lost: expected %0d, actual %0d", e.link_lost, out_data.link_lost);
          err_count++;
        end
        if (out_data.awaiting_pong !== e.awaiting_pong) begin
          $error("awaiting_pong: expected %0d, actual %0d",
                 e.awaiting_pong, out_data.awaiting_pong);
          err_count++;
        end
      end
    end
    if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    #3200000;
    $display("** heartbeat_keepalive_monitor: FAILED **");
    $finish;
  end

  initial begin
    in_word_t w;
    model_link = link_after_reset();
    plan_link  = link_after_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    src_idle_pct  = 6;
    sink_idle_pct = 52;
    queue_event(CMD_RX, 8'hFF);       // first event: byte not looked at
    queue_event(CMD_NONE, BYTE_PING); // invalid command
    queue_event(CMD_RX, BYTE_PING);
    repeat (3) queue_event(CMD_TICK, 8'h00);
    queue_event(CMD_RX, BYTE_PONG);
    queue_event(CMD_RX, 8'h00);       // ignored while idle
    queue_event(CMD_RX, 8'hFF);
    queue_event(CMD_RX, BYTE_PING);
    queue_event(CMD_NONE, 8'h00);
    drain();

    // short period: ping from idle, late pong, then back to idle
    write_reg(CFG_PING_PERIOD, 16'd3);
    write_reg(CFG_PONG_TIMEOUT, 16'd20);
    queue_event(CMD_TICK, 8'h00);
    repeat (4) queue_event(CMD_TICK, 8'h00);
    queue_event(CMD_RX, BYTE_PONG);
    queue_event(CMD_RX, BYTE_PONG);
    queue_event(CMD_TICK, 8'h00);
    drain();

    // smallest values: any tick while waiting would lose the link
    write_reg(CFG_PING_PERIOD, 16'd1);
    write_reg(CFG_PONG_TIMEOUT, 16'd0);
    queue_healthy(140);
    drain();

    src_idle_pct  = 52;
    sink_idle_pct = 6;
    write_reg(CFG_PING_PERIOD, 16'($urandom_range(40, 2)));
    write_reg(CFG_PONG_TIMEOUT, 16'($urandom_range(60, 1)));
    queue_healthy(140);
    while (plan_link.phase != PH_WAIT) queue_event(CMD_TICK, 8'h00);
    sink_hold = 400;   // back up the pipe while the sender keeps offering
    drain();

    // largest values: a long wait for the pong, then back to idle
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_reg(CFG_PING_PERIOD, CNT_MAX);
    write_reg(CFG_PONG_TIMEOUT, CNT_MAX);
    repeat (50) queue_event(CMD_TICK, 8'h00);
    queue_event(CMD_RX, BYTE_PONG);
    queue_event(CMD_TICK, 8'h00);
    drain();

    write_reg(CFG_PING_PERIOD, 16'($urandom_range(60, 5)));
    write_reg(CFG_PONG_TIMEOUT, 16'($urandom_range(90, 2)));
    queue_healthy(120);
    drain();

    // noise at the end: the link goes lost and stays lost
    repeat (60) begin
      w.command = 2'($urandom_range(3));
      w.rx_byte = 8'($urandom_range(255));
      queue_event(w.command, w.rx_byte);
    end
    drain();
    repeat (8) @(posedge clk);

    if (err_count == 0)
      $display("** heartbeat_keepalive_monitor: PASSED **");
    else
      $display("** heartbeat_keepalive_monitor: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/hkm_pkg.sv
rtl/hkm_engine.sv
rtl/heartbeat_keepalive_monitor.sv
sim/tb_top.sv
